/* sv/m64a_pkg.sv */
// shared constants and register codes for the 64-bit murmur key hash
// no dependencies; used by m64a_mul and murmur64a_key_hash_top
`default_nettype none

package m64a_pkg;

    // mixing multiplier and shift
    localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned MUR_R = 47;

    // configuration port
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = CFG_IDX_W'(1);

    // register reset values
    localparam logic [7:0]  KEY_LENGTH_RST = 8'd31;
    localparam logic [63:0] HASH_SEED_RST  = 64'd1860628;

endpackage

`default_nettype wire

/* sv/m64a_mul.sv */
// iterative 64x64 low-half multiply by the murmur constant on one 32x32 multiplier
// depends on m64a_pkg for the constant
`default_nettype none

module m64a_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    output logic             done,
    output logic [63:0]      p
);

    logic        busy_reg;
    logic [1:0]  step_reg;
    logic [63:0] a_reg;
    logic [63:0] pp_reg;
    logic        pp_vld_reg;
    logic        pp_sh_reg;
    logic        pp_last_reg;
    logic [63:0] acc_reg;
    logic        done_reg;

    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] mprod;
    logic [63:0] acc_add;

    // operand select: lo*lo, lo*hi, hi*lo; the hi*hi term falls off the top
    always_comb begin
        mx      = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        my      = (step_reg == 2'd1) ? m64a_pkg::MUR_M[63:32] : m64a_pkg::MUR_M[31:0];
        mprod   = {32'b0, mx} * {32'b0, my};
        acc_add = pp_sh_reg ? {pp_reg[31:0], 32'b0} : pp_reg;
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            step_reg   <= 2'd0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg   <= pp_vld_reg && pp_last_reg;
            pp_vld_reg <= busy_reg;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // partial product register and accumulator
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            pp_reg      <= mprod;
            pp_sh_reg   <= (step_reg != 2'd0);
            pp_last_reg <= (step_reg == 2'd2);
        end
        if (start) begin
            a_reg   <= a;
            acc_reg <= 64'b0;
        end else if (pp_vld_reg) begin
            acc_reg <= acc_reg + acc_add;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

/* sv/murmur64a_key_hash_top.sv */
// 64-bit murmur key hash: one hash per key of configured length, fed as 64-bit words
// depends on m64a_pkg and m64a_mul (shared multiplier)
// each 64-bit multiply runs on the shared 32x32 multiplier as 3 partial products
// full word: 3 multiplies; tail word: 1 multiply
// first word of a key adds a multiply for the seeded start value; last word adds
// a finalization multiply and the output register; empty key: one multiply per word
// aresetn (synchronous) restores key_length 31, the reset seed and an empty key
`default_nettype none

module murmur64a_key_hash_top #(
    parameter int unsigned MAX_KEY_BYTES = 255
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // key word input
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,   // [63:0] key_word
    // hash output
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata,   // [63:0] hash_value
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [m64a_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data
);

    localparam int unsigned WIDX_W = $clog2(MAX_KEY_BYTES / 8 + 2);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_K1      = 3'd2;
    localparam logic [2:0] ST_K2      = 3'd3;
    localparam logic [2:0] ST_HMIX    = 3'd4;
    localparam logic [2:0] ST_TAIL    = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;
    localparam logic [2:0] ST_DELIVER = 3'd7;

    logic [2:0]        state_reg,    state_next;
    logic [7:0]        klen_reg,     klen_next;
    logic [63:0]       seed_reg,     seed_next;
    logic [WIDX_W-1:0] widx_reg,     widx_next;
    logic [63:0]       hash_reg,     hash_next;
    logic [63:0]       word_reg,     word_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg,  m_tdata_next;

    logic              mul_start;
    logic [63:0]       mul_a;
    logic              mul_done;
    logic [63:0]       mul_p;

    logic [7:0]        eff_len;
    logic [7:0]        total_words;
    logic [63:0]       tail_mask;
    logic [WIDX_W-1:0] widx_inc;
    logic              launch;
    logic [63:0]       launch_h;
    logic [63:0]       launch_w;

    m64a_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .done    (mul_done),
        .p       (mul_p)
    );

    // effective length, word count and tail byte mask
    always_comb begin
        eff_len     = (klen_reg > 8'(MAX_KEY_BYTES)) ? 8'(MAX_KEY_BYTES) : klen_reg;
        total_words = {3'b0, eff_len[7:3]} + {7'b0, (eff_len[2:0] != 3'd0)};
        for (int b = 0; b < 8; b++) begin
            tail_mask[b*8 +: 8] = (3'(b) < eff_len[2:0]) ? 8'hFF : 8'h00;
        end
        widx_inc = widx_reg + WIDX_W'(1);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        klen_next     = klen_reg;
        seed_next     = seed_reg;
        widx_next     = widx_reg;
        hash_next     = hash_reg;
        word_next     = word_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mul_start     = 1'b0;
        mul_a         = 64'b0;
        launch        = 1'b0;
        launch_h      = hash_reg;
        launch_w      = word_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    word_next = s_tdata;
                    if (eff_len == 8'd0) begin
                        // empty key: hash of the seed alone
                        mul_start  = 1'b1;
                        mul_a      = seed_reg ^ (seed_reg >> m64a_pkg::MUR_R);
                        state_next = ST_FIN;
                    end else if (widx_reg == '0) begin
                        // first word: seed ^ (len * m)
                        mul_start  = 1'b1;
                        mul_a      = {56'b0, eff_len};
                        state_next = ST_INIT;
                    end else begin
                        launch   = 1'b1;
                        launch_w = s_tdata;
                    end
                end
            end
            ST_INIT: begin
                if (mul_done) begin
                    launch   = 1'b1;
                    launch_h = seed_reg ^ mul_p;
                end
            end
            ST_K1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_p ^ (mul_p >> m64a_pkg::MUR_R);
                    state_next = ST_K2;
                end
            end
            ST_K2: begin
                if (mul_done) begin
                    hash_next  = hash_reg ^ mul_p;
                    mul_start  = 1'b1;
                    mul_a      = hash_reg ^ mul_p;
                    state_next = ST_HMIX;
                end
            end
            ST_HMIX, ST_TAIL: begin
                if (mul_done) begin
                    hash_next = mul_p;
                    if (8'(widx_inc) >= total_words) begin
                        widx_next  = '0;
                        mul_start  = 1'b1;
                        mul_a      = mul_p ^ (mul_p >> m64a_pkg::MUR_R);
                        state_next = ST_FIN;
                    end else begin
                        widx_next  = widx_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (mul_done) begin
                    hash_next  = mul_p ^ (mul_p >> m64a_pkg::MUR_R);
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = hash_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // start a word: full words go through the k mix, the tail goes straight to h
        if (launch) begin
            if (8'(widx_reg) < {3'b0, eff_len[7:3]}) begin
                hash_next  = launch_h;
                mul_start  = 1'b1;
                mul_a      = launch_w;
                state_next = ST_K1;
            end else begin
                hash_next  = launch_h ^ (launch_w & tail_mask);
                mul_start  = 1'b1;
                mul_a      = launch_h ^ (launch_w & tail_mask);
                state_next = ST_TAIL;
            end
        end

        // a key length or hash seed write drops any partial key; other indices are ignored
        if (cfg_valid) begin
            case (cfg_index)
                m64a_pkg::CFG_KEY_LENGTH: begin
                    klen_next = cfg_data[7:0];
                    widx_next = '0;
                end
                m64a_pkg::CFG_HASH_SEED: begin
                    seed_next = cfg_data;
                    widx_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            klen_reg     <= m64a_pkg::KEY_LENGTH_RST;
            seed_reg     <= m64a_pkg::HASH_SEED_RST;
            widx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            klen_reg     <= klen_next;
            seed_reg     <= seed_next;
            widx_reg     <= widx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hash_reg    <= hash_next;
        word_reg    <= word_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an accepted word always starts work when no configuration write is present
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !cfg_valid |=> state_reg != ST_IDLE)
        else $error("accepted word did not start processing");

    // the multiplier only finishes while a multiply state waits for it
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg != ST_IDLE && state_reg != ST_DELIVER)
        else $error("multiplier finished outside a multiply state");

    // word count stays inside the key
    a_widx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        eff_len != 8'd0 |-> 8'(widx_reg) < total_words)
        else $error("word index past end of key");

    // a result is only loaded from the delivery state
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DELIVER)
        else $error("output loaded outside delivery");

endmodule

`default_nettype wire

/* verif/murmur64a_key_hash_top_test.sv */
// self-checking testbench for murmur64a_key_hash_top: key words in, one 64-bit hash per key out
// depends on m64a_pkg and the rtl of murmur64a_key_hash_top; holds its own hash predictor
`default_nettype none

module murmur64a_key_hash_top_test;

    localparam int unsigned IDX_W = m64a_pkg::CFG_IDX_W;
    localparam int unsigned KEY_BYTES_CAP = 255;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned NUM_PHASES = 24;
    localparam int unsigned PHASE_WORDS = 56;
    localparam logic [IDX_W-1:0] CFG_IDX_LAST = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    // stimulus and scoreboard state
    logic [63:0]  key_word_queue[$];
    logic [63:0]  hash_due[$];
    logic         s_taken = 1'b0;
    logic         rx_hold = 1'b0;
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_stall_pct = 0;
    int unsigned  fail_cnt = 0;
    event         rx_hold_kick;

    // predictor state
    logic [7:0]   key_len_q;
    logic [63:0]  seed_q;
    logic [63:0]  run_hash;
    logic [5:0]   words_taken;

    murmur64a_key_hash_top #(
        .MAX_KEY_BYTES(KEY_BYTES_CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- hash predictor ----------------

    function automatic logic [7:0] key_bytes();
        return (key_len_q > KEY_BYTES_CAP) ? 8'(KEY_BYTES_CAP) : key_len_q;
    endfunction

    function automatic logic [63:0] finalize_hash(input logic [63:0] h);
        h ^= h >> m64a_pkg::MUR_R;
        h = h * m64a_pkg::MUR_M;
        h ^= h >> m64a_pkg::MUR_R;
        return h;
    endfunction

    // seeded start value of a new key
    function automatic void restart_key_hash();
        run_hash = seed_q ^ ({56'd0, key_bytes()} * m64a_pkg::MUR_M);
        words_taken = '0;
    endfunction

    function automatic void apply_cfg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        case (idx)
            m64a_pkg::CFG_KEY_LENGTH: begin
                key_len_q = val[7:0];
                restart_key_hash();
            end
            m64a_pkg::CFG_HASH_SEED: begin
                seed_q = val;
                restart_key_hash();
            end
            default: ;
        endcase
    endfunction

    // mix one key word; returns 1 with the finished hash when the key completes
    function automatic bit mix_key_word(input logic [63:0] w, output logic [63:0] h_out);
        logic [7:0]  nbytes;
        logic [5:0]  full_words;
        logic [5:0]  n_words;
        logic [2:0]  tail;
        logic [63:0] k;
        logic [63:0] mask;
        nbytes = key_bytes();
        h_out = '0;
        // empty key: every word yields the hash of nothing
        if (nbytes == 8'd0) begin
            h_out = finalize_hash(seed_q);
            restart_key_hash();
            return 1'b1;
        end
        full_words = {1'b0, nbytes[7:3]};
        tail = nbytes[2:0];
        n_words = full_words + 6'(tail != 3'd0);
        if (words_taken < full_words) begin
            k = w * m64a_pkg::MUR_M;
            k ^= k >> m64a_pkg::MUR_R;
            k = k * m64a_pkg::MUR_M;
            run_hash ^= k;
            run_hash = run_hash * m64a_pkg::MUR_M;
        end else begin
            // tail word: bytes above the tail count are dropped
            mask = (64'd1 << {tail, 3'b000}) - 64'd1;
            run_hash ^= w & mask;
            run_hash = run_hash * m64a_pkg::MUR_M;
        end
        words_taken = words_taken + 6'd1;
        if (words_taken >= n_words) begin
            h_out = finalize_hash(run_hash);
            restart_key_hash();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------- driver, receiver, monitor ----------------

    // key word sender, fed from key_word_queue
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (key_word_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= key_word_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // hash receiver with random stalls
    always @(negedge aclk) begin
        m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off, counted here
    always begin
        @(rx_hold_kick);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // predict on each key word transfer, check on each hash transfer
    always @(posedge aclk) begin
        logic [63:0] fresh_hash;
        logic [63:0] want_hash;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            key_len_q = m64a_pkg::KEY_LENGTH_RST;
            seed_q = m64a_pkg::HASH_SEED_RST;
            restart_key_hash();
            hash_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (mix_key_word(s_tdata, fresh_hash))
                    hash_due.push_back(fresh_hash);
            end
            if (m_tvalid && m_tready) begin
                if (hash_due.size() == 0) begin
                    $error("hash_value: none expected, got 0x%h", m_tdata);
                    fail_cnt++;
                end else begin
                    want_hash = hash_due.pop_front();
                    if (m_tdata !== want_hash) begin
                        $error("hash_value: expected 0x%h, got 0x%h", want_hash, m_tdata);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [63:0] pick_key_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int unsigned words_per_key(input int unsigned nbytes);
        return (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    endfunction

    task automatic queue_key(input int unsigned n_words);
        repeat (n_words) key_word_queue.push_back(pick_key_word());
    endtask

    // register write on the config channel, block idle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_cfg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // all words sent, all hashes back, then let a partial key settle
    task automatic wait_idle();
        @(posedge aclk);
        while (key_word_queue.size() != 0 || s_tvalid || hash_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------- test sequence ----------------

    initial begin
        int unsigned            len_pick;
        int unsigned            n_words;
        int unsigned            budget;
        logic [63:0]            seed_pick;
        logic [63:0]            len_data;
        logic [IDX_W-1:0]       bad_idx;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 31-byte key, three full words and a 7-byte tail
        repeat (4) key_word_queue.push_back('0);
        repeat (4) key_word_queue.push_back('1);
        wait_idle();

        // unknown register index mid-key leaves the key intact
        queue_key(2);
        wait_idle();
        bad_idx = IDX_W'($urandom_range(CFG_IDX_LAST, m64a_pkg::CFG_HASH_SEED + 1));
        write_reg(bad_idx, '1);
        queue_key(2);
        wait_idle();

        // length write drops a partial key
        queue_key(1);
        wait_idle();
        write_reg(m64a_pkg::CFG_KEY_LENGTH, 64'd1);
        key_word_queue.push_back('1);
        key_word_queue.push_back(64'h0123_4567_89ab_cdef);
        wait_idle();

        // single full word, zero seed
        write_reg(m64a_pkg::CFG_KEY_LENGTH, 64'd8);
        write_reg(m64a_pkg::CFG_HASH_SEED, '0);
        key_word_queue.push_back('1);
        key_word_queue.push_back(64'h8000_0000_0000_0001);
        wait_idle();

        // empty key: each word gives the hash of the seed alone
        write_reg(m64a_pkg::CFG_HASH_SEED, '1);
        write_reg(m64a_pkg::CFG_KEY_LENGTH, 64'd0);
        queue_key(3);
        wait_idle();

        // only the low byte of the length write counts
        write_reg(m64a_pkg::CFG_KEY_LENGTH, 64'hffff_ffff_ffff_ff07);
        key_word_queue.push_back('1);
        wait_idle();

        // random phases over settings and idle patterns
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0, 13: len_pick = 255;
                1:     len_pick = 1;
                4:     len_pick = 8;
                9:     len_pick = 0;
                default: begin
                    if ($urandom_range(7) == 0)
                        len_pick = $urandom_range(255, 41);
                    else
                        len_pick = $urandom_range(40, 1);
                end
            endcase
            case (ph)
                0:       seed_pick = '1;
                1:       seed_pick = '0;
                default: seed_pick = {$urandom, $urandom};
            endcase
            len_data = 64'(len_pick);
            if ($urandom_range(1) == 0)
                len_data = ({$urandom, $urandom} & ~64'hff) | len_data;

            if ($urandom_range(3) == 0) begin
                bad_idx = IDX_W'($urandom_range(CFG_IDX_LAST, m64a_pkg::CFG_HASH_SEED + 1));
                write_reg(bad_idx, {$urandom, $urandom});
            end
            if (ph % 2 == 1) begin
                write_reg(m64a_pkg::CFG_HASH_SEED, seed_pick);
                write_reg(m64a_pkg::CFG_KEY_LENGTH, len_data);
            end else begin
                write_reg(m64a_pkg::CFG_KEY_LENGTH, len_data);
                write_reg(m64a_pkg::CFG_HASH_SEED, seed_pick);
            end

            case (ph % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 86;
                end
                default: begin
                    tx_idle_pct = 15;
                    rx_stall_pct = 15;
                end
            endcase

            n_words = words_per_key(len_pick);
            budget = 0;
            while (budget < PHASE_WORDS) begin
                queue_key(n_words);
                budget += n_words;
            end
            // receiver holds off while the sender keeps offering
            if (ph == 4)
                -> rx_hold_kick;
            // leave a partial key behind for the next config write to drop
            if (ph % 3 == 2 && n_words > 1)
                queue_key($urandom_range(n_words - 1, 1));
            wait_idle();
        end

        if (fail_cnt == 0 && hash_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #(64'd20 * 64'd2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
sv/m64a_pkg.sv
sv/m64a_mul.sv
sv/murmur64a_key_hash_top.sv
verif/murmur64a_key_hash_top_test.sv
